// ----- hdl/tie_pkg.sv -----
// shared types and constants for the thread instruction executor
package tie_pkg;

    typedef enum logic [3:0] {
        OP_ADD    = 4'd0,
        OP_SUB    = 4'd1,
        OP_MUL    = 4'd2,
        OP_DIV    = 4'd3,
        OP_MOV    = 4'd4,
        OP_STORE  = 4'd5,
        OP_LOAD   = 4'd6,
        OP_HALT   = 4'd7,
        OP_LOADID = 4'd8,
        OP_JUMP   = 4'd9,
        OP_BEQ    = 4'd10,
        OP_NOP    = 4'd11
    } opcode_t;

    localparam logic [1:0] ST_RUNNING = 2'd0;
    localparam logic [1:0] ST_HALTED  = 2'd1;
    localparam logic [1:0] ST_ENDED   = 2'd2;

    localparam logic CFG_THREAD_ID      = 1'b0;
    localparam logic CFG_PROGRAM_LENGTH = 1'b1;

    typedef struct packed {
        logic [3:0]  opcode;
        logic [3:0]  dest_index;
        logic        first_is_immediate;
        logic [30:0] first_operand;
        logic        second_is_immediate;
        logic [30:0] second_operand;
        logic [9:0]  branch_target;
    } in_item_t;

    typedef struct packed {
        logic [10:0]        next_pc;
        logic [1:0]         run_status;
        logic               reg_written;
        logic [3:0]         written_index;
        logic signed [31:0] written_value;
    } out_item_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;   // capture item, read sources
        logic exec;        // register product and load data, start divide
        logic commit;      // write back and form result
        logic clear_step;  // clearing sweep of the data memory
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic skip;        // halted or past the end
        logic is_div;
        logic div_done;
        logic clear_last;
    } dp_stat_t;

endpackage

// ----- hdl/tie_divider.sv -----
// iterative signed 32-bit divider, one quotient bit per cycle
module tie_divider
    import tie_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [31:0] rem_reg, quo_reg, dsr_reg;
    logic [31:0] rem_next, quo_next;
    logic [5:0]  cnt_reg;
    logic        busy_reg, neg_reg, zero_reg, done_reg;
    logic [32:0] trial;
    logic [32:0] shifted;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[31]};
        trial   = shifted - {1'b0, dsr_reg};
        if (!trial[32])
        begin
            rem_next = trial[31:0];
            quo_next = {quo_reg[30:0], 1'b1};
        end
        else
        begin
            rem_next = shifted[31:0];
            quo_next = {quo_reg[30:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 6'd0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= dividend[31] ? (32'd0 - dividend) : dividend;
            dsr_reg  <= divisor[31] ? (32'd0 - divisor) : divisor;
            neg_reg  <= dividend[31] ^ divisor[31];
            zero_reg <= (divisor == 32'd0);
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign done     = done_reg;
    assign quotient = zero_reg ? 32'd0 : (neg_reg ? (32'd0 - quo_reg) : quo_reg);

endmodule

// ----- hdl/tie_datapath.sv -----
// datapath: register file, data memory, alu and result formation
module tie_datapath
    import tie_pkg::*;
#(
    parameter int REG_COUNT  = 16,
    parameter int MEM_DEPTH  = 1024,
    parameter int PROG_DEPTH = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  dp_cmd_t    cmd,
    output dp_stat_t   stat,
    input  in_item_t   in_item,
    input  logic [9:0] tid_value,
    input  logic [10:0] program_length,
    output out_item_t  result
);

    localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
    localparam int MW = $clog2(MEM_DEPTH);
    // program_length never exceeds 2047, so a larger depth never limits it
    localparam logic [10:0] PROG_CAP = (PROG_DEPTH > 2047) ? 11'd2047 : 11'(PROG_DEPTH);

    logic [31:0] regs_reg [REG_COUNT];
    logic [31:0] mem [MEM_DEPTH];
    logic [31:0] mem_q;
    logic [MW-1:0] clr_reg;

    logic [10:0] pc_reg;
    logic        halted_reg;
    in_item_t    item_reg;
    logic [31:0] a_reg, b_reg, addr_reg;
    logic [31:0] prod_reg;
    logic [RW-1:0] dest_w;
    logic [10:0] limit;
    logic        div_done;
    logic [31:0] div_q;
    logic [10:0] npc;
    logic [31:0] wval;
    logic        wr;
    logic        halt_now;
    logic [1:0]  status;

    assign limit  = (program_length > PROG_CAP) ? PROG_CAP : program_length;
    assign dest_w = RW'(item_reg.dest_index % REG_COUNT);

    function automatic logic [31:0] src(input logic imm, input logic [30:0] op,
                                        input logic [31:0] rv);
        return imm ? {1'b0, op} : rv;
    endfunction

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_item;
            a_reg <= src(in_item.first_is_immediate, in_item.first_operand,
                         regs_reg[RW'(in_item.first_operand % REG_COUNT)]);
            b_reg <= src(in_item.second_is_immediate, in_item.second_operand,
                         regs_reg[RW'(in_item.second_operand % REG_COUNT)]);
            addr_reg <= regs_reg[RW'(in_item.dest_index % REG_COUNT)];
        end
        if (cmd.exec)
            prod_reg <= a_reg * b_reg;
    end

    tie_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.exec),
        .dividend (a_reg),
        .divisor  (b_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // data memory: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
            mem[clr_reg] <= '0;
        else if (cmd.commit && !stat.skip && item_reg.opcode == OP_STORE)
            mem[addr_reg[MW-1:0]] <= a_reg;
        if (cmd.exec)
            mem_q <= mem[a_reg[MW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (cmd.clear_step)
            clr_reg <= clr_reg + MW'(1);
    end

    always_comb
    begin
        npc      = pc_reg + 11'd1;
        wval     = '0;
        wr       = 1'b0;
        halt_now = 1'b0;
        case (item_reg.opcode)
            OP_ADD:    begin wval = a_reg + b_reg; wr = 1'b1; end
            OP_SUB:    begin wval = a_reg - b_reg; wr = 1'b1; end
            OP_MUL:    begin wval = prod_reg; wr = 1'b1; end
            OP_DIV:    begin wval = div_q; wr = 1'b1; end
            OP_MOV:    begin wval = a_reg; wr = 1'b1; end
            OP_LOAD:   begin wval = mem_q; wr = 1'b1; end
            OP_HALT:   begin halt_now = 1'b1; npc = pc_reg; end
            OP_LOADID: begin wval = {22'd0, tid_value}; wr = 1'b1; end
            OP_JUMP:   npc = {1'b0, item_reg.branch_target};
            OP_BEQ:    if (a_reg == b_reg) npc = {1'b0, item_reg.branch_target};
            default:   ;
        endcase
        if (halt_now)
            status = ST_HALTED;
        else if (npc >= limit)
            status = ST_ENDED;
        else
            status = ST_RUNNING;
    end

    assign stat.skip       = halted_reg || (pc_reg >= limit);
    assign stat.is_div     = item_reg.opcode == OP_DIV;
    assign stat.div_done   = div_done;
    assign stat.clear_last = clr_reg == MW'(MEM_DEPTH - 1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg     <= '0;
            halted_reg <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++)
                regs_reg[i] <= '0;
        end
        else if (cmd.commit && !stat.skip)
        begin
            pc_reg <= npc;
            if (halt_now)
                halted_reg <= 1'b1;
            if (wr)
                regs_reg[dest_w] <= wval;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            if (stat.skip)
            begin
                result.next_pc       <= pc_reg;
                result.run_status    <= halted_reg ? ST_HALTED : ST_ENDED;
                result.reg_written   <= 1'b0;
                result.written_index <= '0;
                result.written_value <= '0;
            end
            else
            begin
                result.next_pc       <= npc;
                result.run_status    <= status;
                result.reg_written   <= wr;
                result.written_index <= wr ? 4'(dest_w) : 4'd0;
                result.written_value <= wr ? wval : 32'd0;
            end
        end
    end

endmodule

// ----- hdl/tie_controller.sv -----
// controller: sequences clear sweep, fetch, execute and result handshake
module tie_controller
    import tie_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_EXEC, S_WAIT, S_COMMIT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   accept;
    logic   out_free;

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !(state_reg == S_IDLE);
    assign accept   = in_valid && (state_reg == S_IDLE);

    always_comb
    begin
        cmd            = '0;
        cmd.load_item  = accept;
        cmd.exec       = state_reg == S_EXEC;
        cmd.clear_step = state_reg == S_CLEAR;
        cmd.commit     = (state_reg == S_COMMIT) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_COMMIT) && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR:  if (stat.clear_last) state_reg <= S_IDLE;
                S_IDLE:   if (accept) state_reg <= S_EXEC;
                S_EXEC:
                    if (stat.is_div && !stat.skip)
                        state_reg <= S_WAIT;
                    else
                        state_reg <= S_COMMIT;
                S_WAIT:   if (stat.div_done) state_reg <= S_COMMIT;
                S_COMMIT: if (out_free) state_reg <= S_IDLE;
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_valid = out_valid_reg;

endmodule

// ----- hdl/thread_instruction_executor_core.sv -----
// top level of the thread instruction executor
// Executes one decoded instruction per item against its own pc, register file and
// data memory. An accepted item passes through the exec state, for a divide the wait
// state while the divider forms one quotient bit per cycle, and the commit state, which
// registers the result; a new item is taken only once the previous one has committed,
// and a result waiting in the output register holds back only the commit of the next
// item. After reset the data memory is cleared, one word a cycle, and no item is
// accepted during the sweep; config writes belong between items, with nothing in flight.
module thread_instruction_executor_core
    import tie_pkg::*;
#(
    parameter int REG_COUNT  = 16,
    parameter int MEM_DEPTH  = 1024,
    parameter int PROG_DEPTH = 1024
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    dp_cmd_t     cmd;
    dp_stat_t    stat;
    logic [9:0]  tid_reg;
    logic [10:0] prog_len_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tid_reg      <= '0;
            prog_len_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_THREAD_ID:      tid_reg      <= cfg_data[9:0];
                CFG_PROGRAM_LENGTH: prog_len_reg <= cfg_data[10:0];
                default:            ;
            endcase
        end
    end

    tie_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    tie_datapath #(
        .REG_COUNT  (REG_COUNT),
        .MEM_DEPTH  (MEM_DEPTH),
        .PROG_DEPTH (PROG_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_item        (in_item),
        .tid_value      (tid_reg),
        .program_length (prog_len_reg),
        .result         (out_item)
    );

endmodule
